// ===== rtl/core/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Command codes, status codes, size alignment and sequencer states of the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_CALLOC  = 2'd2;
  localparam logic [1:0] CMD_REALLOC = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BADADDR  = 3'd5;
  localparam logic [2:0] ST_NULLFREE = 3'd6;

  // payload sizes are rounded up to this alignment minus one
  localparam int unsigned ALIGN_M1 = 7;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_PREP   = 8'b0000_0100,
    S_PREP2  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_WRITE2 = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with a block table in address order. Each command
// (alloc, free, calloc, realloc) takes one transfer in and gives exactly one
// result transfer out. The block table lives in one RAM (start, size, free
// mark per entry) and is walked one entry per cycle through its single read
// port; a realloc that moves frees its old entry with a second write. The
// table needs no clearing pass after reset: only entries below the entry
// count are ever read. A new command is taken while the previous result
// still waits in the output register. The user must write heap_limit
// through the cfg port only while the block is idle; the block itself does
// not enforce it. The effective limit is the smaller of heap_limit and the
// largest ADDR_BITS-wide value. Data clearing and copying are only reported
// (zero_length, copy_length, copy_source), never done here.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int ADDR_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_element_count,
  input  logic [31:0] in_block_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_address,
  output logic [2:0]  out_status,
  output logic        out_reused_block,
  output logic [31:0] out_copy_length,
  output logic [31:0] out_copy_source,
  output logic [31:0] out_zero_length,
  // heap_limit write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // --------------------------------------------------------------------------
  // widths and constants
  // --------------------------------------------------------------------------
  localparam int AW = ADDR_BITS;
  localparam int WW = ((AW > 32) ? AW : 32) + 2;       // compare width
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * AW + 1;

  localparam logic [WW-1:0] ADDR_MASK_W = {{(WW-AW){1'b0}}, {AW{1'b1}}};
  localparam logic [64:0]   MASK_65     = {{(65-AW){1'b0}}, {AW{1'b1}}};
  localparam logic [64:0]   ROUND_LIM   = MASK_65 - 65'(ffha_pkg::ALIGN_M1);
  localparam logic [WW-1:0] HDR_W       = WW'(HEADER_BYTES);
  localparam logic [AW-1:0] HDR_A       = AW'(HEADER_BYTES);
  localparam logic [AW:0]   HDR_A1      = (AW+1)'(HEADER_BYTES);
  localparam logic [AW-1:0] ALIGN_A     = AW'(ffha_pkg::ALIGN_M1);
  localparam logic [CW-1:0] MAXB_C      = CW'(MAX_BLOCKS);

  typedef struct packed {
    logic [AW-1:0] start;   // header offset
    logic [AW-1:0] size;    // payload bytes, multiple of 8
    logic          free;
  } entry_t;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  ffha_pkg::state_t state_r, state_nxt;

  logic [31:0]   heap_limit_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] top_r;

  // captured command
  logic [1:0]    cmd_r;
  logic [31:0]   size_r;
  logic [31:0]   elem_r;
  logic [31:0]   baddr_r;

  // size preparation
  logic [63:0]   prod_r;
  logic          ovf_r, big_r, zero_r;
  logic [31:0]   total_r;
  logic [AW-1:0] rounded_r;
  logic [AW:0]   need_r;        // rounded size plus header
  logic [WW-1:0] lim_r;

  // table walk
  logic [CW-1:0] issue_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic          fit_found_r, match_found_r;
  logic [IW-1:0] fit_idx_r, match_idx_r;
  logic [AW-1:0] fit_start_r, fit_size_r;
  logic [AW-1:0] match_start_r, match_size_r;

  // result waiting for the output register
  logic [31:0]   pend_result_r, pend_copy_len_r, pend_copy_src_r, pend_zero_r;
  logic [2:0]    pend_status_r;
  logic          pend_reused_r;

  // output register
  logic          out_valid_r;
  logic [31:0]   out_result_r, out_copy_len_r, out_copy_src_r, out_zero_r;
  logic [2:0]    out_status_r;
  logic          out_reused_r;

  // --------------------------------------------------------------------------
  // RAM
  // --------------------------------------------------------------------------
  logic          ram_wr_en, ram_rd_en;
  logic [IW-1:0] ram_wr_addr, ram_rd_addr;
  entry_t        ram_wr_entry;
  logic [EW-1:0] ram_rd_data;
  entry_t        rd_entry;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (EW'(ram_wr_entry)),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_entry = entry_t'(ram_rd_data);

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic in_xfer, out_free;

  assign in_stall  = (state_r != ffha_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;     // the user writes the limit only while idle; not enforced here
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_result_address = out_result_r;
  assign out_status         = out_status_r;
  assign out_reused_block   = out_reused_r;
  assign out_copy_length    = out_copy_len_r;
  assign out_copy_source    = out_copy_src_r;
  assign out_zero_length    = out_zero_r;

  // --------------------------------------------------------------------------
  // size preparation (PREP stage inputs)
  // --------------------------------------------------------------------------
  logic [63:0]   reqw;
  logic [WW-1:0] lim_w;

  assign reqw  = (cmd_r == ffha_pkg::CMD_CALLOC) ? prod_r : {32'b0, size_r};
  assign lim_w = (WW'(heap_limit_r) > ADDR_MASK_W) ? ADDR_MASK_W : WW'(heap_limit_r);

  // --------------------------------------------------------------------------
  // table walk hits: first free entry big enough, and entry owning baddr
  // --------------------------------------------------------------------------
  logic hit_fit, hit_match;

  assign hit_fit   = rd_vld_r && !fit_found_r && rd_entry.free &&
                     (rd_entry.size >= rounded_r);
  assign hit_match = rd_vld_r && !match_found_r &&
                     ((WW'(rd_entry.start) + HDR_W) == WW'(baddr_r));

  // --------------------------------------------------------------------------
  // decision
  // --------------------------------------------------------------------------
  logic          grow_ok, baddr_nz;
  logic [2:0]    al_status;
  logic [AW-1:0] al_addr;
  logic          al_reused, al_write, al_append;
  logic [IW-1:0] al_idx;
  entry_t        al_entry;
  logic [WW-1:0] al_addr_w, match_size_w;

  logic [2:0]    d_status;
  logic [31:0]   d_result, d_copy_len, d_copy_src, d_zero;
  logic          d_reused, d_write, d_commit, d_write2;
  logic [IW-1:0] d_wr_idx;
  entry_t        d_wr_entry;
  entry_t        match_freed;

  assign grow_ok      = (WW'(top_r) + WW'(need_r)) <= lim_r;
  assign baddr_nz     = (baddr_r != '0);
  assign al_addr_w    = WW'(al_addr);
  assign match_size_w = WW'(match_size_r);
  assign match_freed  = '{start: match_start_r, size: match_size_r, free: 1'b1};

  // allocation of rounded_r: reuse the first fit, else append at heap top
  always_comb begin
    al_status = ffha_pkg::ST_OK;
    al_addr   = '0;
    al_reused = 1'b0;
    al_write  = 1'b0;
    al_append = 1'b0;
    al_idx    = fit_idx_r;
    al_entry  = '{start: fit_start_r, size: fit_size_r, free: 1'b0};
    if (zero_r) begin
      al_status = ffha_pkg::ST_ZERO;
    end else if (big_r) begin
      al_status = ffha_pkg::ST_NOMEM;
    end else if (fit_found_r) begin
      al_addr   = fit_start_r + HDR_A;   // wraps within ADDR_BITS
      al_reused = 1'b1;
      al_write  = 1'b1;
    end else if (count_r >= MAXB_C) begin
      al_status = ffha_pkg::ST_FULL;
    end else if (!grow_ok) begin
      al_status = ffha_pkg::ST_NOMEM;
    end else begin
      al_addr   = top_r + HDR_A;
      al_write  = 1'b1;
      al_append = 1'b1;
      al_idx    = count_r[IW-1:0];
      al_entry  = '{start: top_r, size: rounded_r, free: 1'b0};
    end
  end

  always_comb begin
    d_status   = ffha_pkg::ST_OK;
    d_result   = '0;
    d_reused   = 1'b0;
    d_copy_len = '0;
    d_copy_src = '0;
    d_zero     = '0;
    d_write    = 1'b0;
    d_commit   = 1'b0;
    d_write2   = 1'b0;
    d_wr_idx   = al_idx;
    d_wr_entry = al_entry;
    unique case (cmd_r) inside
      ffha_pkg::CMD_ALLOC: begin
        d_status = al_status;
        d_result = al_addr_w[31:0];
        d_reused = al_reused;
        d_write  = al_write;
        d_commit = al_append;
      end
      ffha_pkg::CMD_CALLOC: begin
        if (ovf_r) begin
          d_status = ffha_pkg::ST_OVERFLOW;
        end else begin
          d_status = al_status;
          d_result = al_addr_w[31:0];
          d_reused = al_reused;
          d_write  = al_write;
          d_commit = al_append;
          if (al_status == ffha_pkg::ST_OK) begin
            d_zero = total_r;
          end
        end
      end
      ffha_pkg::CMD_FREE, ffha_pkg::CMD_REALLOC: begin
        if (cmd_r == ffha_pkg::CMD_FREE || (baddr_nz && size_r == '0)) begin
          // free, or realloc to zero size
          if (!baddr_nz) begin
            d_status = ffha_pkg::ST_NULLFREE;
          end else if (!match_found_r) begin
            d_status = ffha_pkg::ST_BADADDR;
          end else begin
            d_write    = 1'b1;
            d_wr_idx   = match_idx_r;
            d_wr_entry = match_freed;
            d_zero     = match_size_w[31:0];
            if (cmd_r == ffha_pkg::CMD_FREE) begin
              d_result = baddr_r;
            end
          end
        end else if (!baddr_nz) begin
          // realloc of null acts as alloc
          d_status = al_status;
          d_result = al_addr_w[31:0];
          d_reused = al_reused;
          d_write  = al_write;
          d_commit = al_append;
        end else if (!match_found_r) begin
          d_status = ffha_pkg::ST_BADADDR;
        end else if (match_size_w >= WW'(size_r)) begin
          d_result = baddr_r;              // in place, mark untouched
        end else begin
          // move: the old entry is never the first fit, it is too small
          d_status = al_status;
          d_result = al_addr_w[31:0];
          d_reused = al_reused;
          d_write  = al_write;
          d_commit = al_append;
          if (al_status == ffha_pkg::ST_OK) begin
            d_copy_len = match_size_w[31:0];
            d_copy_src = baddr_r;
            d_zero     = match_size_w[31:0];
            d_write2   = 1'b1;
          end
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // RAM port control; writes land before the next walk starts, so reads
  // never race a write to the same entry
  // --------------------------------------------------------------------------
  always_comb begin
    ram_rd_en    = (state_r == ffha_pkg::S_SCAN) && (issue_r < count_r);
    ram_rd_addr  = issue_r[IW-1:0];
    ram_wr_en    = ((state_r == ffha_pkg::S_DECIDE) && d_write) ||
                   (state_r == ffha_pkg::S_WRITE2);
    ram_wr_addr  = (state_r == ffha_pkg::S_WRITE2) ? match_idx_r : d_wr_idx;
    ram_wr_entry = (state_r == ffha_pkg::S_WRITE2) ? match_freed : d_wr_entry;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::S_IDLE:   if (in_xfer) state_nxt = ffha_pkg::S_MUL;
      ffha_pkg::S_MUL:    state_nxt = ffha_pkg::S_PREP;
      ffha_pkg::S_PREP:   state_nxt = ffha_pkg::S_PREP2;
      ffha_pkg::S_PREP2:  state_nxt = ffha_pkg::S_SCAN;
      // last read data is taken in the cycle the issue counter hits count
      ffha_pkg::S_SCAN:   if (issue_r >= count_r) state_nxt = ffha_pkg::S_DECIDE;
      ffha_pkg::S_DECIDE: state_nxt = d_write2 ? ffha_pkg::S_WRITE2 : ffha_pkg::S_DONE;
      ffha_pkg::S_WRITE2: state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE:   if (out_free) state_nxt = ffha_pkg::S_IDLE;
      default:            state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffha_pkg::S_IDLE;
      heap_limit_r <= 32'd65536;
      count_r      <= '0;
      top_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_rd_en;
      if (cfg_valid && cfg_ready) begin
        heap_limit_r <= cfg_data;
      end
      if ((state_r == ffha_pkg::S_DECIDE) && d_commit) begin
        count_r <= count_r + CW'(1);
        top_r   <= top_r + need_r[AW-1:0];   // stays within the limit
      end
      if ((state_r == ffha_pkg::S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_command;
      size_r  <= in_request_size;
      elem_r  <= in_element_count;
      baddr_r <= in_block_address;
    end
    if (state_r == ffha_pkg::S_MUL) begin
      prod_r <= 64'(elem_r) * 64'(size_r);   // exact 32x32 product
    end
    if (state_r == ffha_pkg::S_PREP) begin
      ovf_r     <= {1'b0, reqw} > MASK_65;
      big_r     <= {1'b0, reqw} > ROUND_LIM;
      zero_r    <= (reqw == '0);
      total_r   <= reqw[31:0];
      rounded_r <= (reqw[AW-1:0] + ALIGN_A) & ~ALIGN_A;
    end
    if (state_r == ffha_pkg::S_PREP2) begin
      need_r        <= {1'b0, rounded_r} + HDR_A1;
      lim_r         <= lim_w;
      issue_r       <= '0;
      fit_found_r   <= 1'b0;
      match_found_r <= 1'b0;
    end
    if (ram_rd_en) begin
      issue_r  <= issue_r + CW'(1);
      rd_idx_r <= issue_r[IW-1:0];
    end
    if (hit_fit) begin
      fit_found_r <= 1'b1;
      fit_idx_r   <= rd_idx_r;
      fit_start_r <= rd_entry.start;
      fit_size_r  <= rd_entry.size;
    end
    if (hit_match) begin
      match_found_r <= 1'b1;
      match_idx_r   <= rd_idx_r;
      match_start_r <= rd_entry.start;
      match_size_r  <= rd_entry.size;
    end
    if (state_r == ffha_pkg::S_DECIDE) begin
      pend_result_r   <= d_result;
      pend_status_r   <= d_status;
      pend_reused_r   <= d_reused;
      pend_copy_len_r <= d_copy_len;
      pend_copy_src_r <= d_copy_src;
      pend_zero_r     <= d_zero;
    end
    if ((state_r == ffha_pkg::S_DONE) && out_free) begin
      out_result_r   <= pend_result_r;
      out_status_r   <= pend_status_r;
      out_reused_r   <= pend_reused_r;
      out_copy_len_r <= pend_copy_len_r;
      out_copy_src_r <= pend_copy_src_r;
      out_zero_r     <= pend_zero_r;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_wr_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ffha_pkg::S_DECIDE || state_r == ffha_pkg::S_WRITE2))
    else $error("table write outside commit states");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXB_C)
    else $error("entry count above table depth");

  a_top_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (top_r >= $past(top_r)))
    else $error("heap top moved down");

  a_rd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ffha_pkg::S_SCAN))
    else $error("read data outside table walk");

  a_write2_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::S_WRITE2) |-> $past(state_r == ffha_pkg::S_DECIDE))
    else $error("old block release not right after commit");

endmodule

// ===== rtl/core/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
